>>> hw/rtl/btint_pkg.sv
// ----------------------------------------------------------------------------
// btint_pkg
// Shared widths, register indexes, reset values and control bundles for the
// bilinear table interpolation core.
// ----------------------------------------------------------------------------
`default_nettype none

package btint_pkg;

    localparam int DATA_W      = 32;
    localparam int MAG_W       = 2 * DATA_W;
    localparam int ADDR_IN_W   = 8;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 3;

    localparam int MAX_ROWS_DEF      = 16;
    localparam int MAX_COLUMNS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_BASE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_INV_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_BASE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_INV_STEP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT    = 3'd5;

    localparam logic [DATA_W-1:0]  BASE_RST     = 32'd0;
    localparam logic [DATA_W-1:0]  INV_STEP_RST = 32'd65536;
    localparam logic [COUNT_W-1:0] COUNT_RST    = 5'd16;

    // input item action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // stage enables for one axis position unit
    typedef struct packed {
        logic diff;
        logic mag;
        logic pos;
    } axis_en_t;

    // stage enables for one interpolation unit
    typedef struct packed {
        logic mul;
        logic sum;
    } lerp_en_t;

endpackage

`default_nettype wire

>>> hw/rtl/btint_ram.sv
// ----------------------------------------------------------------------------
// btint_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/btint_axis.sv
// ----------------------------------------------------------------------------
// btint_axis
// Three-stage axis position unit: offset from base, scale by the reciprocal
// step, then split into grid index and ratio with clamping at the edges.
// ----------------------------------------------------------------------------
`default_nettype none

module btint_axis #(
    parameter int FRACTION_BITS = btint_pkg::FRACTION_BITS_DEF,
    parameter int IDX_W         = $clog2(btint_pkg::MAX_ROWS_DEF)
) (
    input  logic                                clk,
    input  btint_pkg::axis_en_t                 en,
    input  logic signed [btint_pkg::DATA_W-1:0] coord,
    input  logic signed [btint_pkg::DATA_W-1:0] base,
    input  logic [btint_pkg::DATA_W-1:0]        inv_step,
    input  logic [IDX_W-1:0]                    limit,
    output logic [IDX_W-1:0]                    idx,
    output logic [FRACTION_BITS-1:0]            ratio
);

    import btint_pkg::*;

    localparam int DIFF_W = DATA_W + 1;
    localparam int GRID_W = MAG_W - 2 * FRACTION_BITS;

    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [MAG_W-1:0]          mag_next;
    logic [MAG_W-1:0]          mag_reg;
    logic [GRID_W-1:0]         grid;
    logic [IDX_W-1:0]          idx_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [FRACTION_BITS-1:0]  ratio_next;
    logic [FRACTION_BITS-1:0]  ratio_reg;

    assign diff_next = DIFF_W'(coord) - DIFF_W'(base);

    // below the base: position zero
    assign mag_next = diff_reg[DIFF_W-1] ? '0
                    : MAG_W'(diff_reg[DATA_W-1:0]) * MAG_W'(inv_step);

    assign grid = mag_reg[MAG_W-1:2*FRACTION_BITS];

    always_comb
    begin
        if (grid >= GRID_W'(limit))
        begin
            idx_next   = limit;
            ratio_next = '0;
        end
        else
        begin
            idx_next   = IDX_W'(grid);
            ratio_next = mag_reg[2*FRACTION_BITS-1:FRACTION_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            diff_reg <= diff_next;
        end
        if (en.mag)
        begin
            mag_reg <= mag_next;
        end
        if (en.pos)
        begin
            idx_reg   <= idx_next;
            ratio_reg <= ratio_next;
        end
    end

    assign idx   = idx_reg;
    assign ratio = ratio_reg;

endmodule

`default_nettype wire

>>> hw/rtl/btint_lerp.sv
// ----------------------------------------------------------------------------
// btint_lerp
// Two-stage linear interpolation: a + floor(ratio * (b - a) / 2^F).
// Multiply in the first stage, shift and add in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module btint_lerp #(
    parameter int IN_W          = btint_pkg::DATA_W,
    parameter int FRACTION_BITS = btint_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  btint_pkg::lerp_en_t      en,
    input  logic signed [IN_W-1:0]   a,
    input  logic signed [IN_W-1:0]   b,
    input  logic [FRACTION_BITS-1:0] ratio,
    output logic signed [IN_W:0]     result
);

    import btint_pkg::*;

    localparam int DIFF_W = IN_W + 1;
    localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [IN_W-1:0]   base_reg;
    logic signed [PROD_W-1:0] step;
    logic signed [IN_W:0]     sum_next;
    logic signed [IN_W:0]     sum_reg;

    assign diff      = DIFF_W'(b) - DIFF_W'(a);
    assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, ratio}));

    // arithmetic shift gives the floor; the step stays within b - a
    assign step     = prod_reg >>> FRACTION_BITS;
    assign sum_next = (IN_W + 1)'(base_reg) + (IN_W + 1)'(step);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg <= prod_next;
            base_reg <= a;
        end
        if (en.sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign result = sum_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bilinear_table_interpolation_core.sv
// ----------------------------------------------------------------------------
// bilinear_table_interpolation_core
// Row-major 2D table of Q16.16 entries with bilinear lookup.
//
// Input channel (in_valid/in_ready) carries one beat per item: action 0
// stores entry_value at entry_address, action 1 looks up the point
// (first_coordinate, second_coordinate). Each lookup returns one beat on the
// output channel (out_valid/out_ready); writes return nothing.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// the user must write it only while no item is in flight; no check enforces it.
// Nine register stages: axis offset, scale multiply, clamp, four table reads
// (four RAM copies, one per corner), two row interpolations in two stages,
// the column interpolation in two stages, and the saturating output register.
// One item enters per cycle unless the output stalls. Writes land in the
// table when they pass the read stage, so every item sees all writes
// accepted before it. Reset clears all stage valid bits and returns the
// configuration registers to their defaults; table contents are undefined
// until written. On a stall each stage holds its item, empty stages still
// fill, and in_ready drops only once every stage up to the input is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_table_interpolation_core #(
    parameter int MAX_ROWS      = btint_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS   = btint_pkg::MAX_COLUMNS_DEF,
    parameter int FRACTION_BITS = btint_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic [btint_pkg::ADDR_IN_W-1:0]        entry_address,
    input  logic signed [btint_pkg::DATA_W-1:0]    entry_value,
    input  logic signed [btint_pkg::DATA_W-1:0]    first_coordinate,
    input  logic signed [btint_pkg::DATA_W-1:0]    second_coordinate,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [btint_pkg::DATA_W-1:0]    interpolated_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [btint_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [btint_pkg::DATA_W-1:0]           cfg_data
);

    import btint_pkg::*;

    localparam int NUM_STAGES = 9;
    localparam int DEPTH      = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
    localparam int COL_IDX_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int WIDE_W     = ADDR_IN_W + ADDR_W;
    localparam int SAT_W      = DATA_W + 2;

    // configuration
    logic signed [DATA_W-1:0] first_base_reg;
    logic [DATA_W-1:0]        first_inv_reg;
    logic signed [DATA_W-1:0] second_base_reg;
    logic [DATA_W-1:0]        second_inv_reg;
    logic [COUNT_W-1:0]       row_count_reg;
    logic [COUNT_W-1:0]       column_count_reg;

    logic [ROW_CNT_W-1:0]     rows_eff;
    logic [COL_CNT_W-1:0]     cols_eff;
    logic [ROW_IDX_W-1:0]     row_limit;
    logic [COL_IDX_W-1:0]     col_limit;

    // pipeline control
    logic [NUM_STAGES:1]      valid_reg;
    logic [NUM_STAGES:1]      en;

    // item carried to the table stage
    logic                     s1_action_reg;
    logic                     s2_action_reg;
    logic                     s3_action_reg;
    logic [ADDR_IN_W-1:0]     s1_addr_reg;
    logic [ADDR_IN_W-1:0]     s2_addr_reg;
    logic [ADDR_IN_W-1:0]     s3_addr_reg;
    logic [DATA_W-1:0]        s1_value_reg;
    logic [DATA_W-1:0]        s2_value_reg;
    logic [DATA_W-1:0]        s3_value_reg;

    axis_en_t                 axis_en;
    logic [ROW_IDX_W-1:0]     row_idx;
    logic [FRACTION_BITS-1:0] row_ratio;
    logic [COL_IDX_W-1:0]     col_idx;
    logic [FRACTION_BITS-1:0] col_ratio;

    // table addressing
    logic [ADDR_W-1:0]        cols_a;
    logic [ADDR_W-1:0]        row_base0;
    logic [ADDR_W-1:0]        row_base1;
    logic [ADDR_W-1:0]        col0;
    logic [ADDR_W-1:0]        col1;
    logic [ADDR_W-1:0]        rd_addr [4];
    logic [DATA_W-1:0]        rd_q [4];
    logic [WIDE_W-1:0]        wr_addr_wide;
    logic                     ram_we;

    // ratios riding along with the reads
    logic [FRACTION_BITS-1:0] s4_row_ratio_reg;
    logic [FRACTION_BITS-1:0] s4_col_ratio_reg;
    logic [FRACTION_BITS-1:0] s5_col_ratio_reg;
    logic [FRACTION_BITS-1:0] s6_col_ratio_reg;

    lerp_en_t                 row_lerp_en;
    lerp_en_t                 col_lerp_en;
    logic signed [DATA_W:0]   top_val;
    logic signed [DATA_W:0]   next_col_val;
    logic signed [SAT_W-1:0]  final_val;
    logic [DATA_W-1:0]        out_value_next;
    logic [DATA_W-1:0]        out_value_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_base_reg   <= BASE_RST;
            first_inv_reg    <= INV_STEP_RST;
            second_base_reg  <= BASE_RST;
            second_inv_reg   <= INV_STEP_RST;
            row_count_reg    <= COUNT_RST;
            column_count_reg <= COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIRST_BASE:      first_base_reg   <= cfg_data;
                REG_FIRST_INV_STEP:  first_inv_reg    <= cfg_data;
                REG_SECOND_BASE:     second_base_reg  <= cfg_data;
                REG_SECOND_INV_STEP: second_inv_reg   <= cfg_data;
                REG_ROW_COUNT:       row_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_COLUMN_COUNT:    column_count_reg <= cfg_data[COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // zero counts act as one, oversize counts as the maximum
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = ROW_CNT_W'(1);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            rows_eff = ROW_CNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = ROW_CNT_W'(row_count_reg);
        end

        if (column_count_reg == '0)
        begin
            cols_eff = COL_CNT_W'(1);
        end
        else if (32'(column_count_reg) > MAX_COLUMNS)
        begin
            cols_eff = COL_CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = COL_CNT_W'(column_count_reg);
        end
    end

    assign row_limit = ROW_IDX_W'(rows_eff - ROW_CNT_W'(1));
    assign col_limit = COL_IDX_W'(cols_eff - COL_CNT_W'(1));

    // ------------------------------------------------------------------
    // pipeline control: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    always_comb
    begin
        en[NUM_STAGES] = !valid_reg[NUM_STAGES] || out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (en[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
            // writes retire at the table stage
            if (en[4])
            begin
                valid_reg[4] <= valid_reg[3] && (s3_action_reg == ACT_LOOKUP);
            end
            for (int k = 5; k <= NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_action_reg <= action;
            s1_addr_reg   <= entry_address;
            s1_value_reg  <= entry_value;
        end
        if (en[2])
        begin
            s2_action_reg <= s1_action_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_value_reg  <= s1_value_reg;
        end
        if (en[3])
        begin
            s3_action_reg <= s2_action_reg;
            s3_addr_reg   <= s2_addr_reg;
            s3_value_reg  <= s2_value_reg;
        end
        if (en[4])
        begin
            s4_row_ratio_reg <= row_ratio;
            s4_col_ratio_reg <= col_ratio;
        end
        if (en[5])
        begin
            s5_col_ratio_reg <= s4_col_ratio_reg;
        end
        if (en[6])
        begin
            s6_col_ratio_reg <= s5_col_ratio_reg;
        end
        if (en[NUM_STAGES])
        begin
            out_value_reg <= out_value_next;
        end
    end

    // ------------------------------------------------------------------
    // axis positions, stages 1 to 3
    // ------------------------------------------------------------------
    assign axis_en.diff = en[1];
    assign axis_en.mag  = en[2];
    assign axis_en.pos  = en[3];

    btint_axis #(
        .FRACTION_BITS (FRACTION_BITS),
        .IDX_W         (ROW_IDX_W)
    ) u_row_axis (
        .clk      (clk),
        .en       (axis_en),
        .coord    (first_coordinate),
        .base     (first_base_reg),
        .inv_step (first_inv_reg),
        .limit    (row_limit),
        .idx      (row_idx),
        .ratio    (row_ratio)
    );

    btint_axis #(
        .FRACTION_BITS (FRACTION_BITS),
        .IDX_W         (COL_IDX_W)
    ) u_col_axis (
        .clk      (clk),
        .en       (axis_en),
        .coord    (second_coordinate),
        .base     (second_base_reg),
        .inv_step (second_inv_reg),
        .limit    (col_limit),
        .idx      (col_idx),
        .ratio    (col_ratio)
    );

    // ------------------------------------------------------------------
    // table stage: corner addresses and writes, read data in stage 4
    // ------------------------------------------------------------------
    assign cols_a    = ADDR_W'(cols_eff);
    assign row_base0 = ADDR_W'(ADDR_W'(row_idx) * cols_a);
    assign row_base1 = (row_ratio != '0) ? row_base0 + cols_a : row_base0;
    assign col0      = ADDR_W'(col_idx);
    assign col1      = (col_ratio != '0) ? col0 + ADDR_W'(1) : col0;

    // corners: row/col, next row/col, row/next col, next row/next col
    assign rd_addr[0] = row_base0 + col0;
    assign rd_addr[1] = row_base1 + col0;
    assign rd_addr[2] = row_base0 + col1;
    assign rd_addr[3] = row_base1 + col1;

    assign wr_addr_wide = WIDE_W'(s3_addr_reg);
    assign ram_we = valid_reg[3] && (s3_action_reg == ACT_WRITE) && en[4]
                 && (wr_addr_wide < WIDE_W'(DEPTH));

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        btint_ram #(
            .WIDTH (DATA_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (ram_we),
            .wr_addr (wr_addr_wide[ADDR_W-1:0]),
            .wr_data (s3_value_reg),
            .rd_en   (en[4]),
            .rd_addr (rd_addr[c]),
            .rd_data (rd_q[c])
        );
    end

    // ------------------------------------------------------------------
    // interpolation: rows in stages 5 and 6, column in stages 7 and 8
    // ------------------------------------------------------------------
    assign row_lerp_en.mul = en[5];
    assign row_lerp_en.sum = en[6];
    assign col_lerp_en.mul = en[7];
    assign col_lerp_en.sum = en[8];

    btint_lerp #(
        .IN_W          (DATA_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_top_lerp (
        .clk    (clk),
        .en     (row_lerp_en),
        .a      ($signed(rd_q[0])),
        .b      ($signed(rd_q[1])),
        .ratio  (s4_row_ratio_reg),
        .result (top_val)
    );

    btint_lerp #(
        .IN_W          (DATA_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_bottom_lerp (
        .clk    (clk),
        .en     (row_lerp_en),
        .a      ($signed(rd_q[2])),
        .b      ($signed(rd_q[3])),
        .ratio  (s4_row_ratio_reg),
        .result (next_col_val)
    );

    btint_lerp #(
        .IN_W          (DATA_W + 1),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_col_lerp (
        .clk    (clk),
        .en     (col_lerp_en),
        .a      (top_val),
        .b      (next_col_val),
        .ratio  (s6_col_ratio_reg),
        .result (final_val)
    );

    // saturate to 32 bits into the output register
    always_comb
    begin
        if (!final_val[SAT_W-1] && (final_val[SAT_W-2:DATA_W-1] != '0))
        begin
            out_value_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (final_val[SAT_W-1] && (final_val[SAT_W-2:DATA_W-1] != '1))
        begin
            out_value_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            out_value_next = final_val[DATA_W-1:0];
        end
    end

    assign out_valid          = valid_reg[NUM_STAGES];
    assign interpolated_value = out_value_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_STAGES-1] && !en[NUM_STAGES] |=> valid_reg[NUM_STAGES-1])
        else $error("stalled stage dropped its beat");

    a_index_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (row_idx <= row_limit) && (col_idx <= col_limit))
        else $error("grid index past table edge");

    a_ratio_inside: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> ((row_ratio == '0) || (row_idx < row_limit))
                      && ((col_ratio == '0) || (col_idx < col_limit)))
        else $error("nonzero ratio on last grid line");

    a_only_lookups_read: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] && $past(en[4]) |-> $past(s3_action_reg) == ACT_LOOKUP)
        else $error("write beat went past the table stage");

endmodule

`default_nettype wire
